// ===== design/fmpd_pkg.sv =====
// Shared constants for the frame motion presence detector: frame geometry,
// derived widths, command, register index and frame status codes. No dependencies.
package fmpd_pkg;

  localparam int FRAME_PIXELS = 4800;
  localparam int ADAPT_STRIDE = 8;
  localparam int SAMPLE_DEPTH = (FRAME_PIXELS + ADAPT_STRIDE - 1) / ADAPT_STRIDE;

  localparam int IDX_W   = $clog2(FRAME_PIXELS);
  localparam int PH_W    = (ADAPT_STRIDE > 1) ? $clog2(ADAPT_STRIDE) : 1;
  localparam int SAMP_AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;

  localparam int PIX_W    = 16;
  localparam int COUNT_W  = 13;
  localparam int CONF_W   = 4;
  localparam int STATUS_W = 3;
  localparam int TIME_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // command field
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ADAPT_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_NEED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_IVL    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN     = 3'd6;

  // frame status codes
  localparam logic [STATUS_W-1:0] ST_IGNORED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REFERENCE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_PRESENCE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNCONFIRMED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SNAPSHOT    = 3'd4;

endpackage

// ===== design/frame_motion_presence_detector_unit.sv =====
// Frame motion presence detector top level: reference and sample memories,
// two-stage read-modify-write pipeline and frame-end decision. Uses fmpd_pkg.
//
// Takes one item per clock: a pixel (command 0) or a millisecond tick (command 1).
// Stage one reads the reference memory and the adapt sample memory at the incoming
// pixel's address; stage two makes the probe decision, compares the pixel, counts
// motion and writes both memories back. The frame result is loaded into the output
// register when the frame's last pixel leaves stage two. Sustained rate is one
// item per cycle; in_ready_o drops only while a result waits in the output register
// and the frame's next result is already in stage two. Reference adaptation after a
// quiet frame needs no extra pass: the stored samples replace every ADAPT_STRIDE-th
// reference read during the next compared frame and are written back there.
// Memories need no clearing pass; the reference is always captured before use.
module frame_motion_presence_detector_unit
  import fmpd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  command_i,
  input  logic [PIX_W-1:0]      pixel_i,
  input  logic                  snapshot_busy_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [STATUS_W-1:0]   frame_status_o,
  output logic [COUNT_W-1:0]    motion_count_o,
  output logic [CONF_W-1:0]     confirm_count_o
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_PIXELS - 1);
  localparam logic [PH_W-1:0]  PH_LAST  = PH_W'(ADAPT_STRIDE - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [CONF_W-1:0]  CONF_MAX  = {CONF_W{1'b1}};

  // configuration registers
  logic        enabled_q;
  logic [7:0]  diff_thresh_q;
  logic [12:0] presence_min_q;
  logic [12:0] adapt_limit_q;
  logic [3:0]  confirm_need_q;
  logic [15:0] probe_ivl_q;
  logic [19:0] cooldown_q;

  // stage one position counters
  logic [IDX_W-1:0]   idx_q;
  logic [PH_W-1:0]    phase_q;
  logic [SAMP_AW-1:0] saddr_q;

  // stage two item
  logic               s1_v_q;
  logic               s1_cmd_q;
  logic [PIX_W-1:0]   s1_px_q;
  logic               s1_busy_q;
  logic               s1_first_q;
  logic               s1_last_q;
  logic               s1_stride_q;
  logic [IDX_W-1:0]   s1_idx_q;
  logic [SAMP_AW-1:0] s1_saddr_q;

  // detector state
  logic                 frame_probed_q;
  logic [COUNT_W-1:0]   motion_q;
  logic                 have_ref_q;
  logic                 adapt_pend_q;
  logic [CONF_W-1:0]    confirm_q;
  logic [TIME_W-1:0]    time_q;
  logic [TIME_W-1:0]    last_probe_q;
  logic [TIME_W-1:0]    last_trig_q;
  logic                 triggered_q;

  // output register
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [COUNT_W-1:0]  out_count_q;
  logic [CONF_W-1:0]   out_conf_q;

  // memories
  logic [PIX_W-1:0] ref_mem  [FRAME_PIXELS];
  logic [PIX_W-1:0] samp_mem [SAMPLE_DEPTH];
  logic [PIX_W-1:0] ref_rd_q;
  logic [PIX_W-1:0] samp_rd_q;

  logic in_accept, stall, s1_fire, s1_pix;

  assign stall      = s1_v_q && (s1_cmd_q == CMD_PIXEL) && s1_last_q
                      && out_valid_q && !out_ready_i;
  assign in_ready_o = !stall;
  assign in_accept  = in_valid_i && in_ready_o;
  assign s1_fire    = s1_v_q && !stall;
  assign s1_pix     = s1_fire && (s1_cmd_q == CMD_PIXEL);

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q      <= 1'b1;
      diff_thresh_q  <= 8'd30;
      presence_min_q <= 13'd480;
      adapt_limit_q  <= 13'd2400;
      confirm_need_q <= 4'd3;
      probe_ivl_q    <= 16'd1000;
      cooldown_q     <= 20'd10000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENABLED:      enabled_q      <= cfg_wdata_i[0];
        CFG_DIFF_THRESH:  diff_thresh_q  <= cfg_wdata_i[7:0];
        CFG_PRESENCE_MIN: presence_min_q <= cfg_wdata_i[12:0];
        CFG_ADAPT_LIMIT:  adapt_limit_q  <= cfg_wdata_i[12:0];
        CFG_CONFIRM_NEED: confirm_need_q <= cfg_wdata_i[3:0];
        CFG_PROBE_IVL:    probe_ivl_q    <= cfg_wdata_i[15:0];
        CFG_COOLDOWN:     cooldown_q     <= cfg_wdata_i[19:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage one: addresses and reads ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      phase_q <= '0;
      saddr_q <= '0;
    end else if (in_accept && (command_i == CMD_PIXEL)) begin
      if (idx_q == IDX_LAST) begin
        idx_q   <= '0;
        phase_q <= '0;
        saddr_q <= '0;
      end else begin
        idx_q <= idx_q + 1'b1;
        if (phase_q == PH_LAST) begin
          phase_q <= '0;
          saddr_q <= saddr_q + 1'b1;
        end else begin
          phase_q <= phase_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (!stall) begin
      s1_v_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cmd_q    <= command_i;
      s1_px_q     <= pixel_i;
      s1_busy_q   <= snapshot_busy_i;
      s1_first_q  <= (idx_q == '0);
      s1_last_q   <= (idx_q == IDX_LAST);
      s1_stride_q <= (phase_q == '0);
      s1_idx_q    <= idx_q;
      s1_saddr_q  <= saddr_q;
    end
  end

  // ---------------- stage two: decide, compare, write back ----------------
  logic probe_ok, cool_block, decide, probed_now;
  logic [TIME_W-1:0] since_probe, since_trig;

  assign since_probe = time_q - last_probe_q;
  assign since_trig  = time_q - last_trig_q;
  assign probe_ok    = enabled_q && !(since_probe < TIME_W'(probe_ivl_q));
  assign cool_block  = triggered_q && (since_trig < TIME_W'(cooldown_q));
  assign decide      = probe_ok && !s1_busy_q && !cool_block;
  assign probed_now  = s1_first_q ? decide : frame_probed_q;

  // pending adaptation substitutes the stored sample at stride positions
  logic [PIX_W-1:0] ref_eff;
  assign ref_eff = (adapt_pend_q && s1_stride_q) ? samp_rd_q : ref_rd_q;

  logic [7:0] dr, dg, db;
  logic [9:0] dsum, thr3;
  logic [8:0] thr1;
  logic       is_motion;

  function automatic logic [7:0] absd(input logic [7:0] a, input logic [7:0] b);
    absd = (a > b) ? (a - b) : (b - a);
  endfunction

  assign dr   = absd({s1_px_q[15:11], 3'b000}, {ref_eff[15:11], 3'b000});
  assign dg   = absd({s1_px_q[10:5], 2'b00}, {ref_eff[10:5], 2'b00});
  assign db   = absd({s1_px_q[4:0], 3'b000}, {ref_eff[4:0], 3'b000});
  assign dsum = {2'b00, dr} + {2'b00, dg} + {2'b00, db};
  // mean over three channels above threshold <=> sum >= 3 * (threshold + 1)
  assign thr1 = {1'b0, diff_thresh_q} + 9'd1;
  assign thr3 = {1'b0, thr1} + {thr1, 1'b0};
  assign is_motion = (dsum >= thr3);

  logic [COUNT_W-1:0] count_base, count_new;
  assign count_base = s1_first_q ? '0 : motion_q;
  assign count_new  = (probed_now && have_ref_q && is_motion && (count_base != COUNT_MAX))
                      ? count_base + 1'b1 : count_base;

  // memory writes
  logic             ref_we, samp_we;
  logic [PIX_W-1:0] ref_wdata;
  assign ref_we    = s1_pix && probed_now && (!have_ref_q || (adapt_pend_q && s1_stride_q));
  assign ref_wdata = have_ref_q ? samp_rd_q : s1_px_q;
  assign samp_we   = s1_pix && probed_now && have_ref_q && s1_stride_q;

  always_ff @(posedge clk_i) begin
    if (ref_we) begin
      ref_mem[s1_idx_q] <= ref_wdata;
    end
    if (in_accept) begin
      ref_rd_q <= ref_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (samp_we) begin
      samp_mem[s1_saddr_q] <= s1_px_q;
    end
    if (in_accept) begin
      samp_rd_q <= samp_mem[saddr_q];
    end
  end

  // frame end decision
  logic [STATUS_W-1:0] st_d;
  logic [COUNT_W-1:0]  cnt_out_d;
  logic [CONF_W-1:0]   conf_d, conf_inc;
  logic                have_ref_d, pend_d, trig_d;

  assign conf_inc = (confirm_q == CONF_MAX) ? CONF_MAX : confirm_q + 1'b1;

  always_comb begin
    st_d       = ST_IGNORED;
    cnt_out_d  = '0;
    conf_d     = confirm_q;
    have_ref_d = have_ref_q;
    pend_d     = adapt_pend_q;
    trig_d     = 1'b0;
    if (probed_now) begin
      if (!have_ref_q) begin
        have_ref_d = 1'b1;
        pend_d     = 1'b0;
        st_d       = ST_REFERENCE;
      end else begin
        cnt_out_d = count_new;
        pend_d    = (count_new < adapt_limit_q);
        if (count_new >= presence_min_q) begin
          if (conf_inc >= confirm_need_q) begin
            conf_d     = '0;
            have_ref_d = 1'b0;
            trig_d     = 1'b1;
            st_d       = ST_SNAPSHOT;
          end else begin
            conf_d = conf_inc;
            st_d   = ST_UNCONFIRMED;
          end
        end else begin
          conf_d = '0;
          st_d   = ST_NO_PRESENCE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_probed_q <= 1'b0;
      motion_q       <= '0;
      have_ref_q     <= 1'b0;
      adapt_pend_q   <= 1'b0;
      confirm_q      <= '0;
      time_q         <= '0;
      last_probe_q   <= '0;
      last_trig_q    <= '0;
      triggered_q    <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == CFG_ENABLED) && !cfg_wdata_i[0]
          && !(s1_pix && s1_last_q)) begin
        confirm_q <= '0;
      end
      if (s1_fire && (s1_cmd_q == CMD_TICK)) begin
        time_q <= time_q + 1'b1;
      end
      if (s1_pix) begin
        motion_q <= count_new;
        if (s1_first_q && probe_ok) begin
          last_probe_q <= time_q;
        end
        if (s1_last_q) begin
          frame_probed_q <= 1'b0;
          have_ref_q     <= have_ref_d;
          adapt_pend_q   <= pend_d;
          confirm_q      <= conf_d;
          if (trig_d) begin
            last_trig_q <= time_q;
            triggered_q <= 1'b1;
          end
        end else begin
          frame_probed_q <= probed_now;
        end
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_pix && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_pix && s1_last_q) begin
      out_status_q <= st_d;
      out_count_q  <= cnt_out_d;
      out_conf_q   <= conf_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_status_o  = out_status_q;
  assign motion_count_o  = out_count_q;
  assign confirm_count_o = out_conf_q;

  // ---------------- assertions ----------------
  a_stall_only_on_full_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_q && !out_ready_i))
    else $error("input held back without a waiting result");

  a_ref_no_read_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ref_we && in_accept && (command_i == CMD_PIXEL)) |-> (s1_idx_q != idx_q))
    else $error("reference read and write hit the same entry");

  a_frame_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_pix && s1_last_q) |=> out_valid_q)
    else $error("frame end did not load the output register");

  a_reference_follows_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(have_ref_q) |-> (out_valid_q && (out_status_q == ST_REFERENCE)))
    else $error("reference marked valid without a capture result");

endmodule

// ===== tb/frame_motion_presence_detector_unit_tb.sv =====
// Self-checking bench for frame_motion_presence_detector_unit: drives whole
// frames and millisecond ticks, tracks the expected per-frame verdicts and
// compares each result. Depends on fmpd_pkg and the detector RTL only.
module frame_motion_presence_detector_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fmpd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;  // beyond the register list
  localparam int DRAIN_CYCLES = 8;
  localparam int TAIL_CYCLES  = 16;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [CONF_W-1:0]   conf;
  } frame_verdict_t;

  // Mirrors the detector state and works out the verdict of every frame.
  class frame_verdict_tracker;
    logic [PIX_W-1:0] ref_image [FRAME_PIXELS];
    logic [PIX_W-1:0] adapt_samples [SAMPLE_DEPTH];
    int unsigned      pix_pos;
    bit               probing;
    bit               have_ref;
    bit               trig_seen;
    bit [COUNT_W-1:0] motion;
    bit [CONF_W-1:0]  streak;
    bit [TIME_W-1:0]  now_ms;
    bit [TIME_W-1:0]  probe_ms;
    bit [TIME_W-1:0]  trigger_ms;
    bit               en;
    bit [7:0]         thresh;
    bit [12:0]        presence_min;
    bit [12:0]        adapt_limit;
    bit [3:0]         need;
    bit [15:0]        probe_ivl;
    bit [19:0]        cooldown;
    frame_verdict_t   due_verdicts [$];
    int unsigned      errors;

    function new();
      pix_pos      = 0;
      probing      = 1'b0;
      have_ref     = 1'b0;
      trig_seen    = 1'b0;
      motion       = '0;
      streak       = '0;
      now_ms       = '0;
      probe_ms     = '0;
      trigger_ms   = '0;
      en           = 1'b1;
      thresh       = 8'd30;
      presence_min = 13'd480;
      adapt_limit  = 13'd2400;
      need         = 4'd3;
      probe_ivl    = 16'd1000;
      cooldown     = 20'd10000;
      errors       = 0;
    endfunction

    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ENABLED: begin
          en = data[0];
          if (!en) streak = '0;
        end
        CFG_DIFF_THRESH:  thresh       = data[7:0];
        CFG_PRESENCE_MIN: presence_min = data[12:0];
        CFG_ADAPT_LIMIT:  adapt_limit  = data[12:0];
        CFG_CONFIRM_NEED: need         = data[3:0];
        CFG_PROBE_IVL:    probe_ivl    = data[15:0];
        CFG_COOLDOWN:     cooldown     = data[19:0];
        default: ;
      endcase
    endfunction

    // Mean of the absolute red, green and blue differences on the 8-bit scale.
    function int unsigned channel_gap(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
      int dr, dg, db;
      dr = int'({a[15:11], 3'b000}) - int'({b[15:11], 3'b000});
      dg = int'({a[10:5], 2'b00}) - int'({b[10:5], 2'b00});
      db = int'({a[4:0], 3'b000}) - int'({b[4:0], 3'b000});
      if (dr < 0) dr = -dr;
      if (dg < 0) dg = -dg;
      if (db < 0) db = -db;
      return (dr + dg + db) / 3;
    endfunction

    function bit probe_decision(bit busy);
      if (!en) return 1'b0;
      if (now_ms - probe_ms < probe_ivl) return 1'b0;
      probe_ms = now_ms;
      if (busy) return 1'b0;
      if (trig_seen && now_ms - trigger_ms < cooldown) return 1'b0;
      return 1'b1;
    endfunction

    function void take_item(logic cmd, logic [PIX_W-1:0] px, logic busy);
      frame_verdict_t v;
      int unsigned    idx;
      int unsigned    k;
      if (cmd == CMD_TICK) begin
        now_ms++;
        return;
      end
      idx = pix_pos;
      if (idx == 0) begin
        probing = probe_decision(busy);
        motion  = '0;
      end
      if (probing) begin
        if (!have_ref) begin
          ref_image[idx] = px;
        end else begin
          if (channel_gap(px, ref_image[idx]) > thresh && motion != '1) motion++;
          if (idx % ADAPT_STRIDE == 0) adapt_samples[idx / ADAPT_STRIDE] = px;
        end
      end
      if (idx + 1 < FRAME_PIXELS) begin
        pix_pos = idx + 1;
        return;
      end
      pix_pos = 0;
      v.count = '0;
      if (!probing) begin
        v.status = ST_IGNORED;
      end else if (!have_ref) begin
        have_ref = 1'b1;
        v.status = ST_REFERENCE;
      end else begin
        v.count = motion;
        // quiet frame: fold the sampled pixels back into the reference
        if (motion < adapt_limit)
          for (k = 0; k < SAMPLE_DEPTH && k * ADAPT_STRIDE < FRAME_PIXELS; k++)
            ref_image[k * ADAPT_STRIDE] = adapt_samples[k];
        if (motion >= presence_min) begin
          if (streak != 4'd15) streak++;
          if (streak >= need) begin
            streak     = '0;
            trigger_ms = now_ms;
            trig_seen  = 1'b1;
            have_ref   = 1'b0;
            v.status   = ST_SNAPSHOT;
          end else begin
            v.status = ST_UNCONFIRMED;
          end
        end else begin
          streak   = '0;
          v.status = ST_NO_PRESENCE;
        end
      end
      probing = 1'b0;
      v.conf  = streak;
      due_verdicts.push_back(v);
    endfunction

    task flag_mismatch(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task match_result(logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] count,
                      logic [CONF_W-1:0] conf);
      frame_verdict_t want;
      if (due_verdicts.size() == 0) begin
        flag_mismatch($sformatf("frame result with none pending, status %0d", status));
        return;
      end
      want = due_verdicts.pop_front();
      if (status !== want.status)
        flag_mismatch($sformatf("frame_status %0d, want %0d", status, want.status));
      if (count !== want.count)
        flag_mismatch($sformatf("motion_count %0d, want %0d", count, want.count));
      if (conf !== want.conf)
        flag_mismatch($sformatf("confirm_count %0d, want %0d", conf, want.conf));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  command_i;
  logic [PIX_W-1:0]      pixel_i;
  logic                  snapshot_busy_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [STATUS_W-1:0]   frame_status_o;
  logic [COUNT_W-1:0]    motion_count_o;
  logic [CONF_W-1:0]     confirm_count_o;

  frame_verdict_tracker verdicts;
  logic [PIX_W-1:0]     scene [FRAME_PIXELS];
  logic [PIX_W-1:0]     frame_px [FRAME_PIXELS];
  bit                   calm_phase;

  frame_motion_presence_detector_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .pixel_i         (pixel_i),
    .snapshot_busy_i (snapshot_busy_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_status_o  (frame_status_o),
    .motion_count_o  (motion_count_o),
    .confirm_count_o (confirm_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned idle_span();
    int unsigned r = $urandom_range(0, 99);
    if (calm_phase || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 12);
  endfunction

  // Random bits above the register width, which the block must drop.
  function automatic logic [CFG_DATA_W-1:0] with_junk(int unsigned value, int unsigned width);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    junk = (junk >> width) << width;
    return junk | CFG_DATA_W'(value);
  endfunction

  function automatic int unsigned pick_motion();
    int unsigned r = $urandom_range(0, 99);
    if (r < 30) return 0;
    if (r < 45) return $urandom_range(1, 200);
    if (r < 75) return $urandom_range(300, 1500);
    if (r < 90) return $urandom_range(1500, 3500);
    return FRAME_PIXELS;
  endfunction

  task automatic send_item(logic cmd, logic [PIX_W-1:0] px, logic busy);
    int unsigned gap;
    gap = idle_span();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    pixel_i         <= px;
    snapshot_busy_i <= busy;
    do @(posedge clk_i); while (!in_ready_o);
    verdicts.take_item(cmd, px, busy);
  endtask

  task automatic pass_ms(int unsigned n);
    repeat (n) send_item(CMD_TICK, PIX_W'($urandom), 1'($urandom));
  endtask

  // Drop valid, wait for every pending verdict, then let the pipeline empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (verdicts.due_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    verdicts.apply_write(idx, data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic new_scene();
    for (int unsigned i = 0; i < FRAME_PIXELS; i++) scene[i] = PIX_W'($urandom);
  endtask

  // Scene with faint sensor noise and one run of freshly random pixels.
  task automatic compose_frame(int unsigned moving);
    int unsigned first;
    first = $urandom_range(0, FRAME_PIXELS - moving);
    for (int unsigned i = 0; i < FRAME_PIXELS; i++)
      if (i >= first && i < first + moving) frame_px[i] = PIX_W'($urandom);
      else if ($urandom_range(0, 3) == 0) frame_px[i] = scene[i] ^ (PIX_W'($urandom) & 16'h0861);
      else frame_px[i] = scene[i];
  endtask

  task automatic stream_pixels(int unsigned lo, int unsigned hi, logic busy_first);
    for (int unsigned i = lo; i < hi; i++) begin
      if ($urandom_range(0, 999) == 0) send_item(CMD_TICK, PIX_W'($urandom), 1'($urandom));
      send_item(CMD_PIXEL, frame_px[i], (i == 0) ? busy_first : 1'($urandom));
    end
  endtask

  task automatic send_frame(int unsigned moving, logic busy_first);
    compose_frame(moving);
    stream_pixels(0, FRAME_PIXELS, busy_first);
  endtask

  task automatic shuffle_settings();
    int unsigned pick;
    // a disable before the enable clears the confirmation streak
    if ($urandom_range(0, 2) == 0) write_reg(CFG_ENABLED, with_junk(0, 1));
    write_reg(CFG_ENABLED, with_junk(($urandom_range(0, 9) != 0), 1));
    pick = $urandom_range(0, 5);
    write_reg(CFG_DIFF_THRESH,
              with_junk(pick == 0 ? 0 : pick == 1 ? 255 : $urandom_range(8, 60), 8));
    pick = $urandom_range(0, 5);
    write_reg(CFG_PRESENCE_MIN, with_junk(pick == 0 ? 0 : pick == 1 ? FRAME_PIXELS :
                                          $urandom_range(100, 1500), 13));
    pick = $urandom_range(0, 5);
    write_reg(CFG_ADAPT_LIMIT, with_junk(pick == 0 ? 0 : pick == 1 ? FRAME_PIXELS :
                                         $urandom_range(0, FRAME_PIXELS), 13));
    pick = $urandom_range(0, 5);
    write_reg(CFG_CONFIRM_NEED,
              with_junk(pick == 0 ? 0 : pick == 1 ? 15 : $urandom_range(1, 4), 4));
    write_reg(CFG_PROBE_IVL, with_junk($urandom_range(0, 6), 16));
    pick = $urandom_range(0, 7);
    write_reg(CFG_COOLDOWN, CFG_DATA_W'(pick == 0 ? 1000000 : $urandom_range(0, 10)));
    if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      verdicts.match_result(frame_status_o, motion_count_o, confirm_count_o);
  end

  initial begin : result_backpressure
    int unsigned stall;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      stall = ($urandom_range(0, 49) == 0) ? $urandom_range(50, 300) : idle_span();
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // Ends the run as failed should it still be going after this delay.
  initial begin
    #(100_000_000);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned f;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CFG_ENABLED;
    cfg_wdata_i     <= '0;
    in_valid_i      <= 1'b0;
    command_i       <= CMD_PIXEL;
    pixel_i         <= '0;
    snapshot_busy_i <= 1'b0;
    calm_phase = 1'b0;
    verdicts = new();
    new_scene();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: too soon after time zero to probe, then a capture
    send_frame(0, 1'b0);
    pass_ms(1000);
    send_frame(0, 1'b0);
    settle();
    write_reg(CFG_DIFF_THRESH, with_junk(30, 8));
    write_reg(CFG_PROBE_IVL, CFG_DATA_W'(0));
    write_reg(CFG_COOLDOWN, CFG_DATA_W'(0));
    write_reg(CFG_SPARE, '1);
    // quiet, two presence frames, a busy snapshot, the trigger, then a fresh capture
    send_frame(0, 1'b0);
    send_frame(1200, 1'b0);
    send_frame(1200, 1'b0);
    send_frame(1200, 1'b1);
    send_frame(1200, 1'b0);
    send_frame(0, 1'b0);
    settle();
    write_reg(CFG_COOLDOWN, CFG_DATA_W'(1000000));
    send_frame(1200, 1'b0);
    settle();
    write_reg(CFG_COOLDOWN, CFG_DATA_W'(4));
    pass_ms(4);
    send_frame(0, 1'b0);
    settle();
    write_reg(CFG_CONFIRM_NEED, CFG_DATA_W'(0));
    send_frame(2000, 1'b0);
    send_frame(0, 1'b0);
    settle();
    write_reg(CFG_DIFF_THRESH, CFG_DATA_W'(0));
    write_reg(CFG_PRESENCE_MIN, CFG_DATA_W'(FRAME_PIXELS));
    write_reg(CFG_ADAPT_LIMIT, CFG_DATA_W'(0));
    write_reg(CFG_CONFIRM_NEED, CFG_DATA_W'(15));
    send_frame(FRAME_PIXELS, 1'b0);
    settle();
    write_reg(CFG_DIFF_THRESH, CFG_DATA_W'(255));
    write_reg(CFG_PRESENCE_MIN, CFG_DATA_W'(0));
    write_reg(CFG_ADAPT_LIMIT, CFG_DATA_W'(FRAME_PIXELS));
    send_frame(FRAME_PIXELS, 1'b0);
    settle();
    write_reg(CFG_DIFF_THRESH, CFG_DATA_W'(30));
    // switch off halfway through a probed frame: it still completes
    compose_frame(1500);
    stream_pixels(0, FRAME_PIXELS / 2, 1'b0);
    settle();
    write_reg(CFG_ENABLED, CFG_DATA_W'(0));
    stream_pixels(FRAME_PIXELS / 2, FRAME_PIXELS, 1'b0);
    send_frame(0, 1'b0);
    settle();
    write_reg(CFG_ENABLED, CFG_DATA_W'(1));
    write_reg(CFG_PROBE_IVL, CFG_DATA_W'(16'hFFFF));
    send_frame(0, 1'b0);

    for (phase = 0; phase < 8; phase++) begin
      settle();
      shuffle_settings();
      calm_phase = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) new_scene();
      for (f = 0; f < 4; f++) begin
        pass_ms($urandom_range(0, 6));
        send_frame(pick_motion(), $urandom_range(0, 9) == 0);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (verdicts.errors == 0 && verdicts.due_verdicts.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/fmpd_pkg.sv
design/frame_motion_presence_detector_unit.sv
tb/frame_motion_presence_detector_unit_tb.sv
